// ===== hdl/mtnp_pkg.sv =====
// Shared types and constants for the MIDI track note pairer.
// No dependencies; imported by mtnp_first_open and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mtnp_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // Track byte codes
   localparam logic [7:0] META_STATUS   = 8'hFF;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [3:0] NOTE_ON_HI    = 4'h9;
   localparam logic [3:0] NOTE_OFF_HI   = 4'h8;
   localparam logic [31:0] TEMPO_LEN    = 32'd3;
   localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;

   // Field widths
   localparam int KEY_W   = 8;
   localparam int VEL_W   = 8;
   localparam int TICK_W  = 32;
   localparam int TEMPO_W = 24;
   localparam int RSP_W   = KEY_W + VEL_W + 2 * TICK_W + TEMPO_W;

   // Open-note flags are searched in groups of this many keys
   localparam int GROUP_W  = 16;
   localparam int GROUP_IW = 4;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_META_TYPE,
      PH_META_LEN,
      PH_META_DATA,
      PH_NOTE_KEY,
      PH_NOTE_VEL
   } phase_type;

   typedef struct packed {
      logic             found;
      logic [KEY_W-1:0] key;
   } find_result_type;

endpackage

`default_nettype wire

// ===== hdl/mtnp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mtnp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mtnp_first_open.sv =====
// Lowest open key search over the open-note flags, two levels of 16.
// Depends on mtnp_pkg for group size and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module mtnp_first_open #(
   parameter int GROUPS = 16
) (
   input  wire logic [GROUPS*16-1:0]         open_flags,
   input  wire logic [GROUPS-1:0]            grp_any,
   output mtnp_pkg::find_result_type         result
);
   import mtnp_pkg::*;

   localparam int GRP_IW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   logic [GRP_IW-1:0]   grp_idx;
   logic                grp_hit;
   logic [GROUP_W-1:0]  grp_bits;
   logic [GROUP_IW-1:0] bit_idx;

   // pick the lowest group that holds an open note
   always_comb begin
      grp_hit = 1'b0;
      grp_idx = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) begin
            grp_hit = 1'b1;
            grp_idx = GRP_IW'(g);
         end
      end
   end

   assign grp_bits = open_flags[{grp_idx, {GROUP_IW{1'b0}}} +: GROUP_W];

   // then the lowest open key inside it
   always_comb begin
      bit_idx = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (grp_bits[i]) begin
            bit_idx = GROUP_IW'(i);
         end
      end
   end

   assign result.found = grp_hit;
   assign result.key   = KEY_W'({grp_idx, bit_idx});

endmodule

`default_nettype wire

// ===== hdl/midi_track_note_pairer_top.sv =====
// Top level of the MIDI track note pairer: byte parser, start-tick RAM, result stage.
// Depends on mtnp_pkg, mtnp_ram and mtnp_first_open.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req_*: one item per track byte (req_tuser = 0, byte in req_tdata) or a drain
//   item (req_tuser = 1) that closes the lowest-keyed open note at track end.
//   rsp_*: one item per closed note, or one track-done item (rsp_tuser = 1,
//   rsp_tdata all zero) when a drain finds no open note.
// Timing
//   A result reaches rsp_tvalid through the result stage and the output register:
//   the accepting cycle parses the item and issues the start-tick RAM read, the
//   result stage takes the RAM data and forms start and duration. Items that cause
//   no result do not enter the result stage. One item is accepted every cycle while
//   req_tready is high; the single read port of the start-tick RAM sets that figure.
// Reset
//   Reset clears the parser, the tick counter and all open-note flags and sets
//   the tempo to 500000 us. The RAM is not cleared: an entry is read only while
//   its open flag is set, so no clearing pass is run. A drain with no open note
//   returns the block to this same state.
// Stalls
//   The output register holds its item while rsp_tready is low; the result stage
//   behind it holds too, and req_tready drops only when both are full.

module midi_track_note_pairer_top #(
   parameter int KEY_COUNT = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // req_tdata: [7:0] byte_value
   input  wire logic [7:0]                req_tdata,
   // req_tuser: [0] req_type
   input  wire logic                      req_tuser,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // rsp_tdata: [7:0] note_key, [15:8] velocity, [47:16] start_tick,
   //            [79:48] duration_ticks, [103:80] tempo_us
   output logic [mtnp_pkg::RSP_W-1:0]     rsp_tdata,
   // rsp_tuser: [0] track_done
   output logic                           rsp_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready
);
   import mtnp_pkg::*;

   localparam int AW      = $clog2(KEY_COUNT);
   localparam int GROUPS  = (KEY_COUNT + GROUP_W - 1) / GROUP_W;
   localparam int FLAG_W  = GROUPS * GROUP_W;
   localparam int FLAG_IW = $clog2(FLAG_W);

   // ---------------- parser state ----------------
   phase_type            phase_ff,  phase_in;
   logic [TICK_W-1:0]    vacc_ff,   vacc_in;
   logic [TICK_W-1:0]    ticks_ff,  ticks_in;
   logic [7:0]           mkind_ff,  mkind_in;
   logic [TICK_W-1:0]    mrem_ff,   mrem_in;
   logic                 mtempo_ff, mtempo_in;
   logic [TEMPO_W-1:0]   tempo_ff,  tempo_in;
   logic [TEMPO_W-1:0]   tbuild_ff, tbuild_in;
   logic                 is_off_ff, is_off_in;
   logic [KEY_W-1:0]     pkey_ff,   pkey_in;
   logic [FLAG_W-1:0]    open_ff,   open_in;
   logic [GROUPS-1:0]    grp_any_ff, grp_any_in;

   // ---------------- result stage ----------------
   logic                 s2_valid_ff, s2_valid_in;
   logic [KEY_W-1:0]     s2_key_ff,   s2_key_in;
   logic [VEL_W-1:0]     s2_vel_ff,   s2_vel_in;
   logic [TICK_W-1:0]    s2_ticks_ff, s2_ticks_in;
   logic [TEMPO_W-1:0]   s2_tempo_ff, s2_tempo_in;
   logic                 s2_done_ff,  s2_done_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff,  rsp_data_in;
   logic                 rsp_done_ff,  rsp_done_in;

   // ---------------- handshake ----------------
   logic                 out_free;
   logic                 s2_adv;
   logic                 accept;

   // ---------------- memory and search ----------------
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [TICK_W-1:0]    ram_rdata;
   find_result_type      find;

   // ---------------- per-item decode ----------------
   logic                 emit;
   logic [KEY_W-1:0]     emit_key;
   logic [VEL_W-1:0]     emit_vel;
   logic                 emit_done;
   logic [TICK_W-1:0]    vacc_shift;
   logic                 key_ok;
   logic [TICK_W-1:0]    mrem_dec;
   logic [TEMPO_W-1:0]   tbuild_shift;
   logic [GROUPS-1:0]    grp_now;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && out_free;
   assign req_tready = !s2_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign vacc_shift   = {vacc_ff[TICK_W-8:0], req_tdata[6:0]};
   assign key_ok       = {1'b0, pkey_ff} < (KEY_W + 1)'(KEY_COUNT);
   assign mrem_dec     = mrem_ff - 1'b1;
   assign tbuild_shift = {tbuild_ff[TEMPO_W-9:0], req_tdata};

   mtnp_first_open #(
      .GROUPS(GROUPS)
   ) u_first_open (
      .open_flags(open_ff),
      .grp_any   (grp_any_ff),
      .result    (find)
   );

   // Next state of the parser, flags and RAM accesses for the accepted item
   always_comb begin
      phase_in  = phase_ff;
      vacc_in   = vacc_ff;
      ticks_in  = ticks_ff;
      mkind_in  = mkind_ff;
      mrem_in   = mrem_ff;
      mtempo_in = mtempo_ff;
      tempo_in  = tempo_ff;
      tbuild_in = tbuild_ff;
      is_off_in = is_off_ff;
      pkey_in   = pkey_ff;
      open_in   = open_ff;
      emit      = 1'b0;
      emit_key  = pkey_ff;
      emit_vel  = req_tdata;
      emit_done = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = pkey_ff[AW-1:0];
      ram_re    = 1'b0;
      ram_raddr = pkey_ff[AW-1:0];

      if (accept) begin
         if (req_tuser == REQ_DRAIN) begin
            emit = 1'b1;
            if (find.found) begin
               // close the lowest open note with release velocity zero
               emit_key  = find.key;
               emit_vel  = '0;
               ram_re    = 1'b1;
               ram_raddr = find.key[AW-1:0];
               open_in[find.key[FLAG_IW-1:0]] = 1'b0;
            end else begin
               // track end: report done and return to the reset state
               emit_done = 1'b1;
               phase_in  = PH_DELTA;
               vacc_in   = '0;
               ticks_in  = '0;
               mkind_in  = '0;
               mrem_in   = '0;
               mtempo_in = 1'b0;
               tempo_in  = TEMPO_DEFAULT;
               tbuild_in = '0;
               is_off_in = 1'b0;
               pkey_in   = '0;
               open_in   = '0;
            end
         end else begin
            unique case (phase_ff)
               PH_DELTA: begin
                  vacc_in = vacc_shift;
                  if (!req_tdata[7]) begin
                     ticks_in = ticks_ff + vacc_shift;
                     vacc_in  = '0;
                     phase_in = PH_STATUS;
                  end
               end
               PH_STATUS: begin
                  if (req_tdata == META_STATUS) begin
                     phase_in = PH_META_TYPE;
                  end else if (req_tdata[7:4] == NOTE_ON_HI) begin
                     is_off_in = 1'b0;
                     phase_in  = PH_NOTE_KEY;
                  end else if (req_tdata[7:4] == NOTE_OFF_HI) begin
                     is_off_in = 1'b1;
                     phase_in  = PH_NOTE_KEY;
                  end else if (!req_tdata[7]) begin
                     // data byte in place of a status: count it as a delta
                     ticks_in = ticks_ff + TICK_W'(req_tdata);
                  end else begin
                     phase_in = PH_DELTA;
                  end
               end
               PH_META_TYPE: begin
                  mkind_in = req_tdata;
                  vacc_in  = '0;
                  phase_in = PH_META_LEN;
               end
               PH_META_LEN: begin
                  vacc_in = vacc_shift;
                  if (!req_tdata[7]) begin
                     mrem_in   = vacc_shift;
                     vacc_in   = '0;
                     mtempo_in = (mkind_ff == META_TEMPO) && (vacc_shift == TEMPO_LEN);
                     tbuild_in = '0;
                     phase_in  = (vacc_shift == '0) ? PH_DELTA : PH_META_DATA;
                  end
               end
               PH_META_DATA: begin
                  if (mtempo_ff) begin
                     tbuild_in = tbuild_shift;
                  end
                  mrem_in = mrem_dec;
                  if (mrem_dec == '0) begin
                     if (mtempo_ff) begin
                        tempo_in = tbuild_shift;
                     end
                     phase_in = PH_DELTA;
                  end
               end
               PH_NOTE_KEY: begin
                  pkey_in  = req_tdata;
                  phase_in = PH_NOTE_VEL;
               end
               PH_NOTE_VEL: begin
                  phase_in = PH_DELTA;
                  if (key_ok) begin
                     if (!is_off_ff && (req_tdata != '0)) begin
                        // note-on: record start tick, overwrite a re-struck key
                        ram_we = 1'b1;
                        open_in[pkey_ff[FLAG_IW-1:0]] = 1'b1;
                     end else if (open_ff[pkey_ff[FLAG_IW-1:0]]) begin
                        emit   = 1'b1;
                        ram_re = 1'b1;
                        open_in[pkey_ff[FLAG_IW-1:0]] = 1'b0;
                     end
                  end
               end
               default: begin
                  phase_in = PH_DELTA;
               end
            endcase
         end
      end
   end

   // Group summary follows the flags so the search sees it without lag
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = |open_in[g*GROUP_W +: GROUP_W];
         grp_now[g]    = |open_ff[g*GROUP_W +: GROUP_W];
      end
   end

   mtnp_ram #(
      .WIDTH(TICK_W),
      .DEPTH(KEY_COUNT)
   ) u_start_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ticks_ff),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Result stage: load a new emitting item, hold while the output is full
   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_key_in   = s2_key_ff;
      s2_vel_in   = s2_vel_ff;
      s2_ticks_in = s2_ticks_ff;
      s2_tempo_in = s2_tempo_ff;
      s2_done_in  = s2_done_ff;
      if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
      if (accept) begin
         s2_valid_in = emit;
         s2_key_in   = emit_key;
         s2_vel_in   = emit_vel;
         s2_ticks_in = ticks_ff;
         s2_tempo_in = tempo_ff;
         s2_done_in  = emit_done;
      end
   end

   // Output register: duration from the close tick and the RAM start tick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = s2_done_ff;
         if (s2_done_ff) begin
            rsp_data_in = '0;
         end else begin
            rsp_data_in = {s2_tempo_ff, s2_ticks_ff - ram_rdata, ram_rdata,
                           s2_vel_ff, s2_key_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DELTA;
         vacc_ff      <= '0;
         ticks_ff     <= '0;
         mkind_ff     <= '0;
         mrem_ff      <= '0;
         mtempo_ff    <= 1'b0;
         tempo_ff     <= TEMPO_DEFAULT;
         tbuild_ff    <= '0;
         is_off_ff    <= 1'b0;
         pkey_ff      <= '0;
         open_ff      <= '0;
         grp_any_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         vacc_ff      <= vacc_in;
         ticks_ff     <= ticks_in;
         mkind_ff     <= mkind_in;
         mrem_ff      <= mrem_in;
         mtempo_ff    <= mtempo_in;
         tempo_ff     <= tempo_in;
         tbuild_ff    <= tbuild_in;
         is_off_ff    <= is_off_in;
         pkey_ff      <= pkey_in;
         open_ff      <= open_in;
         grp_any_ff   <= grp_any_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_key_ff   <= s2_key_in;
      s2_vel_ff   <= s2_vel_in;
      s2_ticks_ff <= s2_ticks_in;
      s2_tempo_ff <= s2_tempo_in;
      s2_done_ff  <= s2_done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_done_ff;

   // ---------------- assertions ----------------
   a_grp_summary: assert property (@(posedge clock) disable iff (reset)
      grp_any_ff == grp_now)
      else $error("group summary out of step with open flags");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_data_ff == '0)
      else $error("track-done item carries nonzero data");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == REQ_DRAIN) && !find.found
      |=> (open_ff == '0) && (phase_ff == PH_DELTA) && (tempo_ff == TEMPO_DEFAULT))
      else $error("track end did not return to reset state");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_free |=> s2_valid_ff && $stable(s2_key_ff) && $stable(ram_rdata))
      else $error("result stage lost its item under stall");

endmodule

`default_nettype wire
